// ===== design/page_framebuffer_region_ops_top_macros.svh =====
// ----------------------------------------------------------------------------
// Page framebuffer region ops: assertion macros
// Concurrent assertion wrappers clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_REGION_OPS_TOP_MACROS_SVH
`define PAGE_FRAMEBUFFER_REGION_OPS_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PFB_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Check a property on every clock edge, reset included.
`define PFB_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: reset assertion failed");

`endif

// ===== design/pfb_pkg.sv =====
// ----------------------------------------------------------------------------
// Page framebuffer package
// Geometry constants, item kinds and memory port bundles shared by the block.
// ----------------------------------------------------------------------------
package pfb_pkg;

  localparam int WIDTH       = 128;
  localparam int HEIGHT      = 64;
  localparam int GLYPH_BYTES = 256;

  localparam int PAGES       = (HEIGHT + 7) / 8;
  localparam int FRAME_BYTES = WIDTH * PAGES;

  localparam int FA_W = $clog2(FRAME_BYTES);
  localparam int GA_W = $clog2(GLYPH_BYTES);
  localparam int PG_W = (PAGES > 1) ? $clog2(PAGES) : 1;

  // Clipped column ends reach 128 and row ends 64, sums of two 8-bit fields reach 510.
  localparam int END_W = 9;
  // Glyph row base: 5-bit row-of-bytes index times 8-bit stride.
  localparam int GB_W  = 13;
  // Glyph index: base plus 8-bit column offset.
  localparam int GI_W  = 14;

  typedef enum logic [2:0] {
    K_SET    = 3'd0,
    K_CLR    = 3'd1,
    K_INV    = 3'd2,
    K_ZERO   = 3'd3,
    K_GLYPH  = 3'd4,
    K_LOAD   = 3'd5,
    K_CLRALL = 3'd6,
    K_READ   = 3'd7
  } kind_t;

  typedef struct packed {
    logic            we;
    logic [FA_W-1:0] waddr;
    logic [7:0]      wdata;
    logic [FA_W-1:0] raddr;
  } fr_req_t;

  typedef struct packed {
    logic            we;
    logic [GA_W-1:0] addr;
    logic [7:0]      data;
  } gl_wr_t;

  typedef struct packed {
    logic [GA_W-1:0] addr_lo;
    logic [GA_W-1:0] addr_hi;
  } gl_rd_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } res_t;

endpackage

// ===== design/pfb_stream_if.sv =====
// ----------------------------------------------------------------------------
// Page framebuffer stream interfaces
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface pfb_in_if;
  import pfb_pkg::*;

  logic       valid;
  logic       ready;
  kind_t      kind;
  logic [7:0] x;
  logic [7:0] y;
  logic [7:0] width;
  logic [7:0] height;
  logic [9:0] index;
  logic [7:0] value;

  modport source (output valid, kind, x, y, width, height, index, value, input ready);
  modport sink   (input valid, kind, x, y, width, height, index, value, output ready);
  modport mon    (input valid, ready, kind, x, y, width, height, index, value);
endinterface

interface pfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
  modport mon    (input valid, ready, read_data);
endinterface

// ===== design/pfb_frame_mem.sv =====
// ----------------------------------------------------------------------------
// Page framebuffer frame memory
// One write port and one registered read port over the page-organized frame.
// ----------------------------------------------------------------------------
module pfb_frame_mem (
  input  logic             clk,
  input  pfb_pkg::fr_req_t req,
  output logic [7:0]       rdata
);
  import pfb_pkg::*;

  logic [7:0] mem [FRAME_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// ===== design/pfb_glyph_mem.sv =====
// ----------------------------------------------------------------------------
// Page framebuffer glyph memory
// One write port and two registered read ports for the straddling glyph rows.
// ----------------------------------------------------------------------------
module pfb_glyph_mem (
  input  logic            clk,
  input  pfb_pkg::gl_wr_t wr,
  input  pfb_pkg::gl_rd_t rd,
  output logic [7:0]      rdata_lo,
  output logic [7:0]      rdata_hi
);
  import pfb_pkg::*;

  logic [7:0] mem [GLYPH_BYTES];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_lo <= mem[rd.addr_lo];
    rdata_hi <= mem[rd.addr_hi];
  end

endmodule

// ===== design/pfb_walker.sv =====
// ----------------------------------------------------------------------------
// Page framebuffer region walker
// Sequencer that decodes items, sweeps clipped rectangles page by page with a
// read-modify-write pipeline, runs clearing passes and serves byte reads.
// ----------------------------------------------------------------------------
module pfb_walker (
  input  logic             clk,
  input  logic             rst_n,
  pfb_in_if.sink           in_ch,
  output pfb_pkg::fr_req_t fr_req,
  input  logic [7:0]       fr_rdata,
  output pfb_pkg::gl_wr_t  gl_wr,
  output pfb_pkg::gl_rd_t  gl_rd,
  input  logic [7:0]       gl_rdata_lo,
  input  logic [7:0]       gl_rdata_hi,
  output pfb_pkg::res_t    res,
  input  logic             slot_free
);
  import pfb_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_PSETUP = 6'b000100,
    S_WALK   = 6'b001000,
    S_RDATA  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  kind_t             kind_r, kind_nxt;
  logic [7:0]        x_r, x_nxt;
  logic [7:0]        y_r, y_nxt;
  logic [7:0]        w_r, w_nxt;
  logic [END_W-1:0]  xe_r, xe_nxt;
  logic [END_W-1:0]  ye_r, ye_nxt;
  logic [PG_W-1:0]   page_r, page_nxt;
  logic [PG_W-1:0]   last_page_r, last_page_nxt;
  logic [7:0]        col_r, col_nxt;
  logic [7:0]        off_r, off_nxt;
  logic [7:0]        mask_r, mask_nxt;
  logic [GB_W-1:0]   gbase_lo_r, gbase_lo_nxt;
  logic [GB_W-1:0]   gbase_hi_r, gbase_hi_nxt;
  logic [FA_W-1:0]   pbase_r, pbase_nxt;
  logic [FA_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic              clr_cmd_r, clr_cmd_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [7:0]        res_r, res_nxt;
  logic              s2_valid_r, s2_valid_nxt;
  logic [FA_W-1:0]   s2_addr_r, s2_addr_nxt;
  logic              s2_gv_lo_r, s2_gv_lo_nxt;
  logic              s2_gv_hi_r, s2_gv_hi_nxt;

  logic              in_acc;
  logic [END_W-1:0]  xsum, ysum, xe_c, ye_c;
  logic              empty_c;
  logic [END_W-1:0]  ps, pe, lo, hi, yl, dlo, dhi, row;
  logic [4:0]        klo, khi;
  logic [7:0]        mask_c;
  logic [FA_W-1:0]   walk_raddr;
  logic [GI_W-1:0]   g_lo, g_hi;
  logic              gv_lo, gv_hi, last_col;
  logic [7:0]        glyph_or, new_byte;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Clip the rectangle at accept time.
  always_comb begin
    xsum    = END_W'(in_ch.x) + END_W'(in_ch.width);
    ysum    = END_W'(in_ch.y) + END_W'(in_ch.height);
    xe_c    = (xsum > END_W'(WIDTH)) ? END_W'(WIDTH) : xsum;
    ye_c    = (ysum > END_W'(HEIGHT)) ? END_W'(HEIGHT) : ysum;
    empty_c = (END_W'(in_ch.x) >= xe_c) || (END_W'(in_ch.y) >= ye_c);
  end

  // Per-page setup: covered row mask and the glyph row bases of the first
  // and last covered row in this page (a page straddles at most two).
  always_comb begin
    ps  = END_W'({page_r, 3'b000});
    pe  = ps + END_W'(7);
    yl  = ye_r - END_W'(1);
    lo  = (ps > END_W'(y_r)) ? ps : END_W'(y_r);
    hi  = (pe < yl) ? pe : yl;
    dlo = lo - END_W'(y_r);
    dhi = hi - END_W'(y_r);
    klo = dlo[7:3];
    khi = dhi[7:3];
    row = '0;
    for (int b = 0; b < 8; b++) begin
      row       = ps + END_W'(b);
      mask_c[b] = (row >= END_W'(y_r)) && (row < ye_r);
    end
  end

  // Column step: frame address and glyph indices for the current byte.
  always_comb begin
    walk_raddr = pbase_r + FA_W'(col_r);
    g_lo       = GI_W'(gbase_lo_r) + GI_W'(off_r);
    g_hi       = GI_W'(gbase_hi_r) + GI_W'(off_r);
    gv_lo      = g_lo < GI_W'(GLYPH_BYTES);
    gv_hi      = g_hi < GI_W'(GLYPH_BYTES);
    last_col   = (END_W'(col_r) + END_W'(1)) == xe_r;
  end

  assign gl_rd.addr_lo = g_lo[GA_W-1:0];
  assign gl_rd.addr_hi = g_hi[GA_W-1:0];

  // Modify stage: frame and glyph bytes arrive in the cycle after the read.
  always_comb begin
    glyph_or = (s2_gv_lo_r ? gl_rdata_lo : 8'd0) | (s2_gv_hi_r ? gl_rdata_hi : 8'd0);
    case (kind_r)
      K_SET:   new_byte = fr_rdata | mask_r;
      K_CLR:   new_byte = fr_rdata & ~mask_r;
      K_INV:   new_byte = fr_rdata ^ mask_r;
      K_ZERO:  new_byte = 8'd0;
      K_GLYPH: new_byte = fr_rdata | glyph_or;
      default: new_byte = fr_rdata;
    endcase
  end

  // Addresses within one sweep are all distinct and the last write lands
  // before the next item is taken, so no forwarding path is needed.
  always_comb begin
    fr_req.we    = (state_r == S_CLEAR) ? 1'b1 : s2_valid_r;
    fr_req.waddr = (state_r == S_CLEAR) ? clr_cnt_r : s2_addr_r;
    fr_req.wdata = (state_r == S_CLEAR) ? 8'd0 : new_byte;
    fr_req.raddr = (state_r == S_IDLE) ? FA_W'(in_ch.index) : walk_raddr;
  end

  always_comb begin
    gl_wr.we   = in_acc && (in_ch.kind == K_LOAD) && (int'(in_ch.index) < GLYPH_BYTES);
    gl_wr.addr = GA_W'(in_ch.index);
    gl_wr.data = in_ch.value;
  end

  assign res.valid = (state_r == S_DONE);
  assign res.data  = res_r;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    w_nxt         = w_r;
    xe_nxt        = xe_r;
    ye_nxt        = ye_r;
    page_nxt      = page_r;
    last_page_nxt = last_page_r;
    col_nxt       = col_r;
    off_nxt       = off_r;
    mask_nxt      = mask_r;
    gbase_lo_nxt  = gbase_lo_r;
    gbase_hi_nxt  = gbase_hi_r;
    pbase_nxt     = pbase_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_cmd_nxt   = clr_cmd_r;
    rd_ok_nxt     = rd_ok_r;
    res_nxt       = res_r;
    s2_valid_nxt  = (state_r == S_WALK);
    s2_addr_nxt   = walk_raddr;
    s2_gv_lo_nxt  = gv_lo;
    s2_gv_hi_nxt  = gv_hi;

    case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + FA_W'(1);
        if (clr_cnt_r == FA_W'(FRAME_BYTES - 1)) begin
          state_nxt = clr_cmd_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          kind_nxt = in_ch.kind;
          res_nxt  = 8'd0;
          case (in_ch.kind)
            K_SET, K_CLR, K_INV, K_ZERO, K_GLYPH: begin
              x_nxt         = in_ch.x;
              y_nxt         = in_ch.y;
              w_nxt         = in_ch.width;
              xe_nxt        = xe_c;
              ye_nxt        = ye_c;
              page_nxt      = PG_W'(in_ch.y >> 3);
              last_page_nxt = PG_W'((ye_c - END_W'(1)) >> 3);
              col_nxt       = in_ch.x;
              off_nxt       = 8'd0;
              state_nxt     = empty_c ? S_DONE : S_PSETUP;
            end
            K_CLRALL: begin
              clr_cnt_nxt = '0;
              clr_cmd_nxt = 1'b1;
              state_nxt   = S_CLEAR;
            end
            K_READ: begin
              rd_ok_nxt = int'(in_ch.index) < FRAME_BYTES;
              state_nxt = S_RDATA;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_PSETUP: begin
        mask_nxt     = mask_c;
        gbase_lo_nxt = GB_W'(klo) * GB_W'(w_r);
        gbase_hi_nxt = GB_W'(khi) * GB_W'(w_r);
        pbase_nxt    = FA_W'(int'(page_r) * WIDTH);
        state_nxt    = S_WALK;
      end
      S_WALK: begin
        col_nxt = col_r + 8'd1;
        off_nxt = off_r + 8'd1;
        if (last_col) begin
          col_nxt = x_r;
          off_nxt = 8'd0;
          if (page_r == last_page_r) begin
            state_nxt = S_DONE;
          end else begin
            page_nxt  = page_r + PG_W'(1);
            state_nxt = S_PSETUP;
          end
        end
      end
      S_RDATA: begin
        res_nxt   = rd_ok_r ? fr_rdata : 8'd0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_cnt_r  <= '0;
      clr_cmd_r  <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      clr_cmd_r  <= clr_cmd_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    w_r         <= w_nxt;
    xe_r        <= xe_nxt;
    ye_r        <= ye_nxt;
    page_r      <= page_nxt;
    last_page_r <= last_page_nxt;
    col_r       <= col_nxt;
    off_r       <= off_nxt;
    mask_r      <= mask_nxt;
    gbase_lo_r  <= gbase_lo_nxt;
    gbase_hi_r  <= gbase_hi_nxt;
    pbase_r     <= pbase_nxt;
    rd_ok_r     <= rd_ok_nxt;
    res_r       <= res_nxt;
    s2_addr_r   <= s2_addr_nxt;
    s2_gv_lo_r  <= s2_gv_lo_nxt;
    s2_gv_hi_r  <= s2_gv_hi_nxt;
  end

endmodule

// ===== design/page_framebuffer_region_ops_top.sv =====
// ----------------------------------------------------------------------------
// Page framebuffer region ops: top level
// Monochrome frame store in 8-row byte pages with rectangle commands.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one command item (kind, x, y, width, height, index, value);
//   out_ch returns exactly one item per command with read_data, which is the
//   frame byte for a read and zero for every other kind.
//   Commands run one at a time; in_ch.ready is high only while the sequencer
//   is idle. A rectangle command sweeps each covered page in a setup step
//   and a walk over its clipped columns; the frame memory's single
//   read-modify-write pipeline moves one byte per cycle along each page row.
//   A clear-all zeroes the frame with a clearing pass over all FRAME_BYTES
//   bytes; after reset the same pass runs while in_ch.ready stays low.
//   The result sits in an output register; the next command is accepted
//   while it waits. If out_ch stalls, a finished command holds in the
//   sequencer until the register frees, and no further command is taken.
// ----------------------------------------------------------------------------
module page_framebuffer_region_ops_top (
  input  logic      clk,
  input  logic      rst_n,
  pfb_in_if.sink    in_ch,
  pfb_out_if.source out_ch
);
  import pfb_pkg::*;

  fr_req_t    fr_req;
  logic [7:0] fr_rdata;
  gl_wr_t     gl_wr;
  gl_rd_t     gl_rd;
  logic [7:0] gl_rdata_lo;
  logic [7:0] gl_rdata_hi;
  res_t       res;
  logic       slot_free;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r, out_data_nxt;

  pfb_walker u_walker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .fr_req      (fr_req),
    .fr_rdata    (fr_rdata),
    .gl_wr       (gl_wr),
    .gl_rd       (gl_rd),
    .gl_rdata_lo (gl_rdata_lo),
    .gl_rdata_hi (gl_rdata_hi),
    .res         (res),
    .slot_free   (slot_free)
  );

  pfb_frame_mem u_frame_mem (
    .clk   (clk),
    .req   (fr_req),
    .rdata (fr_rdata)
  );

  pfb_glyph_mem u_glyph_mem (
    .clk      (clk),
    .wr       (gl_wr),
    .rd       (gl_rd),
    .rdata_lo (gl_rdata_lo),
    .rdata_hi (gl_rdata_hi)
  );

  assign slot_free = !out_valid_r || out_ch.ready;

  // Load a finished item when the register is empty or draining; hold it
  // while the receiver stalls.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res.valid && slot_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res.data;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_data_r;

endmodule

// ===== design/pfb_checker.sv =====
// ----------------------------------------------------------------------------
// Page framebuffer port checker
// Watches the top level's channels for sequencing and output-hold errors.
// ----------------------------------------------------------------------------
`include "page_framebuffer_region_ops_top_macros.svh"

module pfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_data
);

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  // One command at a time: the input is closed in the cycle after an accept.
  `PFB_ASSERT(a_busy_after_accept, in_acc |=> !in_ready)

  // A result never appears in the cycle right after a command is taken.
  `PFB_ASSERT(a_no_instant_result, in_acc |=> !$rose(out_valid))

  // A stalled result stays put.
  `PFB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_read_data))

  // Reset drops the result and starts the clearing pass.
  `PFB_ASSERT_RST(a_reset_state, !rst_n |=> !out_valid && !in_ready)

endmodule

bind page_framebuffer_region_ops_top pfb_checker u_pfb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_read_data (out_ch.read_data)
);
